>>> hdl/lipd_pkg.sv
// Package for the lock-in pixel demodulator: command codes, controller and
// datapath handshake structs, and the constant functions that build the tables.
// Depends on nothing.
`default_nettype none

package lipd_pkg;

  typedef enum logic [1:0] {
    CMD_ACC     = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  typedef enum logic [0:0] {
    REG_START_TIME = 1'b0,
    REG_PHASE_RATE = 1'b1
  } cfg_reg_e;

  localparam int unsigned SUM_W        = 48;
  localparam int unsigned MEAN_W       = 26;
  localparam int unsigned ANGLE_W      = 16;
  localparam int unsigned FRAME_W      = 16;
  localparam int unsigned SAMPLE_W     = 16;
  localparam int unsigned PIX_W        = 16;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned CFG_W        = 32;
  localparam int unsigned IN_DATA_W    = 64;
  localparam int unsigned OUT_DATA_W   = 96;
  localparam int unsigned DIV_STEPS    = 49;
  localparam int unsigned CORDIC_STEPS = 31;
  localparam int unsigned SQRT_STEPS   = 26;
  localparam int unsigned CNT_W        = 6;

  localparam longint unsigned HALF_PI_Q30       = 64'd1686629713;
  localparam longint unsigned TURNS_PER_RAD_Q32 = 64'd683565276;

  typedef struct packed {
    logic             mem_rd;
    logic             phase;
    logic             look;
    logic             mul;
    logic             wr;
    logic             restart;
    logic             div_ld;
    logic             div_sel_q;
    logic             div_step;
    logic             mean_st;
    logic             mean_sel_q;
    logic             sq;
    logic             sumsq;
    logic             iter;
    logic             fin;
    logic [CNT_W-1:0] step;
  } lipd_ctl_t;

  typedef struct packed {
    cmd_e cmd;
    logic in_range;
    logic frames_zero;
    logic frames_sat;
    logic out_busy;
  } lipd_sts_t;

  // Quarter-wave sine entry in Q1.15 from a truncated Q30 Taylor series.
  function automatic logic [15:0] sine_entry(input int unsigned k, input int unsigned tb);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          s;
    longint          r;
    x = (64'(k) * HALF_PI_Q30) >> tb;
    x2 = (x * x) >> 30;
    term = x;
    s = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n & 1) == 1) s = s - longint'(term);
      else s = s + longint'(term);
    end
    if (s < 0) s = 0;
    r = (s + 16384) >>> 15;
    if (r > 32767) r = 32767;
    return r[15:0];
  endfunction

  // CORDIC arctangent step in 2^-32 turns.
  function automatic logic [31:0] arc_entry(input int unsigned i);
    longint          rad;
    longint unsigned t;
    longint unsigned p;
    rad = 0;
    if (i == 0) return 32'h2000_0000;
    for (int unsigned j = 0; j < 17; j++) begin
      if (i * (2 * j + 1) <= 32) begin
        t = (64'd1 << (32 - i * (2 * j + 1))) / 64'(2 * j + 1);
        if ((j & 1) == 1) rad = rad - longint'(t);
        else rad = rad + longint'(t);
      end
    end
    p = (64'(rad) * TURNS_PER_RAD_Q32 + 64'h8000_0000) >> 32;
    return p[31:0];
  endfunction

endpackage

`default_nettype wire

>>> hdl/lipd_ctrl.sv
// Controller state machine of the lock-in pixel demodulator.
// Sequences the datapath through lipd_ctl_t commands; uses lipd_pkg.
`default_nettype none

module lipd_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  accept_i,
  input  lipd_pkg::lipd_sts_t  sts_i,
  output logic                 ready_o,
  output lipd_pkg::lipd_ctl_t  ctl_o
);
  import lipd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_PHASE, ST_LOOK, ST_MUL, ST_WRITE,
    ST_DIVI_LD, ST_DIVI, ST_DIVQ_LD, ST_DIVQ, ST_MEANQ,
    ST_SQ, ST_SUMSQ, ST_ITER, ST_DONE
  } state_e;

  state_e    state_q;
  logic      ready_q;
  lipd_ctl_t ctl_q;

  // The command register holds the action the datapath performs at the end
  // of the current state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
      ctl_q   <= '0;
    end else begin
      ctl_q <= '0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept_i) begin
            state_q      <= ST_DECODE;
            ready_q      <= 1'b0;
            ctl_q.mem_rd <= 1'b1;
          end
        end
        ST_DECODE: begin
          unique case (sts_i.cmd)
            CMD_ACC: begin
              if (sts_i.frames_sat) begin
                state_q <= ST_IDLE;
                ready_q <= 1'b1;
              end else begin
                state_q     <= ST_PHASE;
                ctl_q.phase <= 1'b1;
              end
            end
            CMD_READ: begin
              if (!sts_i.frames_zero && sts_i.in_range) begin
                state_q      <= ST_DIVI_LD;
                ctl_q.div_ld <= 1'b1;
              end else begin
                state_q   <= ST_DONE;
                ctl_q.fin <= 1'b1;
              end
            end
            CMD_RESTART: begin
              state_q       <= ST_IDLE;
              ready_q       <= 1'b1;
              ctl_q.restart <= 1'b1;
            end
            default: begin
              state_q <= ST_IDLE;
              ready_q <= 1'b1;
            end
          endcase
        end
        ST_PHASE: begin
          state_q    <= ST_LOOK;
          ctl_q.look <= 1'b1;
        end
        ST_LOOK: begin
          state_q   <= ST_MUL;
          ctl_q.mul <= 1'b1;
        end
        ST_MUL: begin
          state_q  <= ST_WRITE;
          ctl_q.wr <= 1'b1;
        end
        ST_WRITE: begin
          state_q <= ST_IDLE;
          ready_q <= 1'b1;
        end
        ST_DIVI_LD: begin
          state_q        <= ST_DIVI;
          ctl_q.div_step <= 1'b1;
        end
        ST_DIVI: begin
          if (ctl_q.step == CNT_W'(DIV_STEPS - 1)) begin
            state_q         <= ST_DIVQ_LD;
            ctl_q.mean_st   <= 1'b1;
            ctl_q.div_ld    <= 1'b1;
            ctl_q.div_sel_q <= 1'b1;
          end else begin
            ctl_q.div_step <= 1'b1;
            ctl_q.step     <= ctl_q.step + 1'b1;
          end
        end
        ST_DIVQ_LD: begin
          state_q        <= ST_DIVQ;
          ctl_q.div_step <= 1'b1;
        end
        ST_DIVQ: begin
          if (ctl_q.step == CNT_W'(DIV_STEPS - 1)) begin
            state_q          <= ST_MEANQ;
            ctl_q.mean_st    <= 1'b1;
            ctl_q.mean_sel_q <= 1'b1;
          end else begin
            ctl_q.div_step <= 1'b1;
            ctl_q.step     <= ctl_q.step + 1'b1;
          end
        end
        ST_MEANQ: begin
          state_q  <= ST_SQ;
          ctl_q.sq <= 1'b1;
        end
        ST_SQ: begin
          state_q     <= ST_SUMSQ;
          ctl_q.sumsq <= 1'b1;
        end
        ST_SUMSQ: begin
          state_q    <= ST_ITER;
          ctl_q.iter <= 1'b1;
        end
        ST_ITER: begin
          if (ctl_q.step == CNT_W'(CORDIC_STEPS - 1)) begin
            state_q   <= ST_DONE;
            ctl_q.fin <= 1'b1;
          end else begin
            ctl_q.iter <= 1'b1;
            ctl_q.step <= ctl_q.step + 1'b1;
          end
        end
        ST_DONE: begin
          // The result register loads only once the previous beat is gone.
          if (!sts_i.out_busy) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
          end else begin
            ctl_q.fin <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign ready_o = ready_q;
  assign ctl_o   = ctl_q;

endmodule

`default_nettype wire

>>> hdl/lipd_dp.sv
// Datapath of the lock-in pixel demodulator: pixel sum memories, phase and
// table lookup, divider, square root and CORDIC, result register. Uses lipd_pkg.
`default_nettype none

module lipd_dp #(
  parameter int unsigned NUM_PIXELS = 65536,
  parameter int unsigned TABLE_BITS = 10
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           accept_i,
  input  wire [lipd_pkg::IN_DATA_W-1:0] in_data_i,
  input  wire                           in_last_i,
  input  wire [1:0]                     in_user_i,
  input  wire                           cfg_we_i,
  input  wire [0:0]                     cfg_idx_i,
  input  wire [lipd_pkg::CFG_W-1:0]     cfg_data_i,
  input  lipd_pkg::lipd_ctl_t           ctl_i,
  output lipd_pkg::lipd_sts_t           sts_o,
  input  wire                           out_ready_i,
  output logic                          out_valid_o,
  output logic                          out_user_o,
  output logic [lipd_pkg::OUT_DATA_W-1:0] out_data_o
);
  import lipd_pkg::*;

  localparam int unsigned AW      = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
  localparam int unsigned TSIZE   = 1 << TABLE_BITS;
  localparam int unsigned TA_W    = TABLE_BITS + 1;
  localparam int unsigned IDX_W   = TABLE_BITS + 2;
  localparam int unsigned PROD_W  = 35;
  localparam int unsigned DN_W    = DIV_STEPS;
  localparam int unsigned DV_W    = FRAME_W + 7;
  localparam int unsigned SQ_W    = 2 * MEAN_W;
  localparam int unsigned CORD_W  = 60;
  localparam logic [MEAN_W-1:0] MEAN_MAX = {1'b0, {(MEAN_W-1){1'b1}}};
  localparam logic [MEAN_W-1:0] MEAN_MIN = {1'b1, {(MEAN_W-1){1'b0}}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};

  // Latched input item.
  cmd_e                cmd_q;
  logic [PIX_W-1:0]    pix_q;
  logic [SAMPLE_W-1:0] smp_q;
  logic [TIME_W-1:0]   ts_q;
  logic                fend_q;

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      cmd_q  <= cmd_e'(in_user_i);
      pix_q  <= in_data_i[15:0];
      smp_q  <= in_data_i[31:16];
      ts_q   <= in_data_i[63:32];
      fend_q <= in_last_i;
    end
  end

  // Configuration and frame count.
  logic [TIME_W-1:0]  start_q, rate_q;
  logic [FRAME_W-1:0] frames_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      rate_q   <= '0;
      frames_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_reg_e'(cfg_idx_i) == REG_START_TIME) start_q <= cfg_data_i;
        else rate_q <= cfg_data_i;
      end
      if (ctl_i.restart) frames_q <= '0;
      else if (ctl_i.wr && fend_q) frames_q <= frames_q + 1'b1;
    end
  end

  logic [AW-1:0] addr;
  logic          in_range;
  assign addr     = AW'(pix_q);
  assign in_range = 32'(pix_q) < 32'(NUM_PIXELS);

  // Pixel sum memories.
  logic [SUM_W-1:0] sum_i_mem [NUM_PIXELS];
  logic [SUM_W-1:0] sum_q_mem [NUM_PIXELS];
  logic [SUM_W-1:0] rdi_q, rdq_q, new_i, new_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr && in_range) begin
      sum_i_mem[addr] <= new_i;
      sum_q_mem[addr] <= new_q;
    end
    if (ctl_i.mem_rd) begin
      rdi_q <= sum_i_mem[addr];
      rdq_q <= sum_q_mem[addr];
    end
  end

  // Reference phase and quarter-wave table.
  logic [TIME_W-1:0] phase_q;
  logic [IDX_W-1:0]  idx;
  logic [TA_W-1:0]   lo_a, hi_a;
  logic [15:0]       rom [TSIZE+1];
  logic [15:0]       lo_q, hi_q;
  logic [1:0]        quad_q;

  for (genvar k = 0; k <= TSIZE; k++) begin : g_rom
    assign rom[k] = sine_entry(k, TABLE_BITS);
  end

  assign idx  = phase_q[TIME_W-1 -: IDX_W];
  assign lo_a = {1'b0, idx[TABLE_BITS-1:0]};
  assign hi_a = TA_W'(TSIZE) - lo_a;

  always_ff @(posedge clk_i) begin
    if (ctl_i.phase) phase_q <= 32'(rate_q * (ts_q - start_q));
    if (ctl_i.look) begin
      lo_q   <= rom[lo_a];
      hi_q   <= rom[hi_a];
      quad_q <= idx[IDX_W-1 -: 2];
    end
  end

  // Products 2 * sample * cos and 2 * sample * sin.
  logic signed [16:0] lo_s, hi_s, sn, cs, smp_s;
  logic signed [33:0] pi_w, pq_w;
  logic [PROD_W-1:0]  pi_q, pq_q;

  assign lo_s  = signed'({1'b0, lo_q});
  assign hi_s  = signed'({1'b0, hi_q});
  assign smp_s = signed'({1'b0, smp_q});

  always_comb begin
    unique case (quad_q)
      2'd0: begin sn = lo_s;  cs = hi_s;  end
      2'd1: begin sn = hi_s;  cs = -lo_s; end
      2'd2: begin sn = -lo_s; cs = -hi_s; end
      default: begin sn = -hi_s; cs = lo_s; end
    endcase
  end

  assign pi_w = smp_s * cs;
  assign pq_w = smp_s * sn;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) begin
      pi_q <= {pi_w, 1'b0};
      pq_q <= {pq_w, 1'b0};
    end
  end

  function automatic logic [SUM_W-1:0] acc_next(input logic [SUM_W-1:0] old,
                                                input logic [PROD_W-1:0] p,
                                                input logic first);
    logic [SUM_W-1:0] pe;
    logic [SUM_W:0]   s;
    pe = {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
    s  = {old[SUM_W-1], old} + {pe[SUM_W-1], pe};
    if (first) return pe;
    if (s[SUM_W] != s[SUM_W-1]) return s[SUM_W] ? SUM_MIN : SUM_MAX;
    return s[SUM_W-1:0];
  endfunction

  assign new_i = acc_next(rdi_q, pi_q, frames_q == '0);
  assign new_q = acc_next(rdq_q, pq_q, frames_q == '0);

  // Restoring divider for the rounded mean, one quotient bit per cycle.
  logic [SUM_W-1:0] acc_sel, mag;
  logic [DN_W-1:0]  dn_q;
  logic [DV_W-1:0]  rem_q, dv;
  logic [DV_W:0]    trial, trial_sub;
  logic             neg_q, ge;

  assign acc_sel   = ctl_i.div_sel_q ? rdq_q : rdi_q;
  assign mag       = acc_sel[SUM_W-1] ? (~acc_sel + 1'b1) : acc_sel;
  assign dv        = {frames_q, 7'b0};
  assign trial     = {rem_q, dn_q[DN_W-1]};
  assign ge        = trial >= {1'b0, dv};
  assign trial_sub = trial - {1'b0, dv};

  always_ff @(posedge clk_i) begin
    if (ctl_i.div_ld) begin
      dn_q  <= {1'b0, mag} + {{(DN_W-FRAME_W-6){1'b0}}, frames_q, 6'b0};
      rem_q <= '0;
      neg_q <= acc_sel[SUM_W-1];
    end else if (ctl_i.div_step) begin
      rem_q <= ge ? trial_sub[DV_W-1:0] : trial[DV_W-1:0];
      dn_q  <= {dn_q[DN_W-2:0], ge};
    end
  end

  function automatic logic [MEAN_W-1:0] mean_clamp(input logic [DN_W-1:0] q, input logic neg);
    logic [DN_W-1:0] nq;
    nq = ~q + 1'b1;
    if (neg) begin
      if (q > {{(DN_W-MEAN_W){1'b0}}, MEAN_MIN}) return MEAN_MIN;
      return nq[MEAN_W-1:0];
    end
    if (q > {{(DN_W-MEAN_W){1'b0}}, MEAN_MAX}) return MEAN_MAX;
    return q[MEAN_W-1:0];
  endfunction

  logic signed [MEAN_W-1:0] mi_q, mq_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mean_st) begin
      if (ctl_i.mean_sel_q) mq_q <= mean_clamp(dn_q, neg_q);
      else mi_q <= mean_clamp(dn_q, neg_q);
    end
  end

  // Squares, then a shared iteration phase for square root and CORDIC.
  logic signed [SQ_W-1:0]   sqi_w, sqq_w;
  logic [SQ_W-2:0]          sqi_q, sqq_q;
  logic [SQ_W-1:0]          v_q, r_q, bit_q, rb;
  logic signed [CORD_W-1:0] xi_w, yi_w, x_q, y_q, dx, dy;
  logic [31:0]              z_q;
  logic [31:0]              arc [CORDIC_STEPS];
  logic [4:0]               it;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_arc
    assign arc[i] = arc_entry(i);
  end

  assign sqi_w = mi_q * mi_q;
  assign sqq_w = mq_q * mq_q;
  assign xi_w  = CORD_W'(mi_q) <<< 30;
  assign yi_w  = CORD_W'(mq_q) <<< 30;
  assign it    = ctl_i.step[4:0];
  assign dx    = y_q >>> it;
  assign dy    = x_q >>> it;
  assign rb    = r_q + bit_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.sq) begin
      sqi_q <= sqi_w[SQ_W-2:0];
      sqq_q <= sqq_w[SQ_W-2:0];
      // A negative in-phase mean mirrors the vector through the origin.
      x_q   <= mi_q[MEAN_W-1] ? -xi_w : xi_w;
      y_q   <= mi_q[MEAN_W-1] ? -yi_w : yi_w;
      z_q   <= mi_q[MEAN_W-1] ? 32'h8000_0000 : 32'h0;
    end
    if (ctl_i.sumsq) begin
      v_q   <= {1'b0, sqi_q} + {1'b0, sqq_q};
      r_q   <= '0;
      bit_q <= SQ_W'(1) << (2 * SQRT_STEPS - 2);
    end
    if (ctl_i.iter) begin
      if (y_q > 0) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + arc[it];
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - arc[it];
      end
      if (ctl_i.step < CNT_W'(SQRT_STEPS)) begin
        if (v_q >= rb) begin
          v_q <= v_q - rb;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
    end
  end

  // Result register.
  logic                  res_ok, zero_vec, fin_go;
  logic [SQ_W-1:0]       amp;
  logic [31:0]           zr;
  logic [ANGLE_W-1:0]    ang;
  logic                  out_valid_q, out_user_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  assign res_ok   = (frames_q != '0) && in_range;
  assign zero_vec = (mi_q == '0) && (mq_q == '0);
  assign amp      = r_q + SQ_W'(v_q > r_q);
  assign zr       = z_q + 32'h0000_8000;
  assign ang      = zero_vec ? '0 : zr[31:16];
  assign fin_go   = ctl_i.fin && !(out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go) begin
      out_user_q <= res_ok;
      out_data_q <= res_ok ? {2'b00, ang, amp[MEAN_W-1:0], mq_q, mi_q} : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_user_o  = out_user_q;
  assign out_data_o  = out_data_q;

  assign sts_o.cmd         = cmd_q;
  assign sts_o.in_range    = in_range;
  assign sts_o.frames_zero = frames_q == '0;
  assign sts_o.frames_sat  = frames_q == '1;
  assign sts_o.out_busy    = out_valid_q && !out_ready_i;

endmodule

`default_nettype wire

>>> hdl/lock_in_pixel_demodulator.sv
// Lock-in pixel demodulator, top level: stream ports, configuration port,
// controller and datapath. Depends on lipd_pkg, lipd_ctrl and lipd_dp.
//
// Usage: each input beat carries a command in s_axis_tuser. An accumulate
// beat adds twice the sample times the reference cosine and sine to the
// pixel's in-phase and quadrature sums (the first frame overwrites them);
// s_axis_tlast on an accumulate beat closes a frame. A read beat returns one
// result beat with the per-frame means, their magnitude and their angle;
// m_axis_tuser is low with all-zero data when no frame is complete or the
// pixel lies outside the array. A restart beat clears the frame count.
// start_time and phase_rate are written through cfg_we_i; the user must
// write them only while idle, which the block itself does not enforce. An
// accumulate beat occupies the block through decode, the 32x32 phase
// multiply, the table read, the sample multiply and the read-modify-write
// of the sum memories. A read runs two 49-step restoring divisions and the
// 31-step CORDIC that the square root runs beside. Restart and unused
// commands end after decode. One beat is worked at a time. Reset clears the
// frame count and both registers; the sum memories are not cleared and hold
// data only once written. A finished result waits in the output register
// while the receiver stalls; the next input beat is still taken, and a later
// read holds in its last step until the register frees up.
`default_nettype none

module lock_in_pixel_demodulator #(
  parameter int unsigned NUM_PIXELS = 65536,
  parameter int unsigned TABLE_BITS = 10
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,   // pixel_index[15:0], sample[31:16], timestamp[63:32]
  input  wire         s_axis_tlast,   // frame_end
  input  wire  [1:0]  s_axis_tuser,   // cmd[1:0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [95:0] m_axis_tdata,   // in_phase[25:0], quadrature[51:26],
                                      // amplitude[77:52], angle[93:78]
  output logic        m_axis_tuser,   // valid_res
  input  wire         cfg_we_i,
  input  wire  [0:0]  cfg_idx_i,
  input  wire  [31:0] cfg_data_i
);
  import lipd_pkg::*;

  lipd_ctl_t ctl;
  lipd_sts_t sts;
  logic      ready;
  logic      accept;

  assign accept        = s_axis_tvalid && ready;
  assign s_axis_tready = ready;

  lipd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .sts_i    (sts),
    .ready_o  (ready),
    .ctl_o    (ctl)
  );

  lipd_dp #(
    .NUM_PIXELS (NUM_PIXELS),
    .TABLE_BITS (TABLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .in_user_i   (s_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_user_o  (m_axis_tuser),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

>>> hdl/lipd_chk.sv
// Port-level checker for the lock-in pixel demodulator and its bind.
// Depends on the top level's ports only.
`default_nettype none

module lipd_chk (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [95:0] m_axis_tdata,
  input wire        m_axis_tuser
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its data.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // An invalid result carries all-zero data.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("invalid result with nonzero data");

  // The block works one beat at a time, so it is busy after an accept.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken on back-to-back cycles");

endmodule

bind lock_in_pixel_demodulator lipd_chk u_lipd_chk (.*);

`default_nettype wire

>>> tb/sv/tb_lock_in_pixel_demodulator.sv
// Self-checking testbench for the lock-in pixel demodulator: drives command
// beats, predicts each read result and compares it field by field.
// Depends on lipd_pkg and lock_in_pixel_demodulator.
`default_nettype none

module tb_lock_in_pixel_demodulator;
  import lipd_pkg::*;

  // Cycles without any accepted beat before the run is declared hung.
  localparam int unsigned HANG_LIMIT = 40000;
  localparam int unsigned HOLD_CYCLES = 1500;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned FRAME_RUN = 60;
  localparam longint SUM_TOP = 64'sd140737488355327;
  localparam longint SUM_BOTTOM = -64'sd140737488355328;
  localparam longint MEAN_TOP = 33554431;
  localparam longint MEAN_BOTTOM = -33554432;

  typedef struct packed {
    logic        valid_res;
    logic [25:0] in_phase;
    logic [25:0] quadrature;
    logic [25:0] amplitude;
    logic [15:0] angle;
  } pixel_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // pixel_index[15:0], sample[31:16], timestamp[63:32]
  logic        s_axis_tlast = 1'b0; // frame_end
  logic [1:0]  s_axis_tuser = CMD_ACC; // cmd[1:0]
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [95:0] m_axis_tdata;        // in_phase[25:0], quadrature[51:26],
                                    // amplitude[77:52], angle[93:78]
  wire         m_axis_tuser;        // valid_res
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = REG_START_TIME;
  logic [31:0] cfg_data_i = '0;

  lock_in_pixel_demodulator dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor state: the two registers, the frame count and the sums of
  // every pixel touched so far. The sum arrays stand in for the memories.
  // ---------------------------------------------------------------------
  logic [31:0]   ref_start_time;
  logic [31:0]   ref_phase_rate;
  int unsigned   frame_count;
  longint        in_phase_acc[int];
  longint        quad_acc[int];
  bit            fresh_pixel[int];   // sampled since the last restart
  int            fresh_list[$];
  longint        sine_q15[0:1024];
  longint unsigned atan_turns[0:30];
  pixel_result_t pending_results[$];
  int unsigned   error_count = 0;

  // Sender idle and receiver stall odds, in percent, per phase.
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   recv_hold = 0;

  // The quarter-wave table is a truncated Q30 Taylor series rounded to
  // Q1.15; the arctangent steps are Q32 radian series scaled to turns.
  task automatic build_lookup_tables();
    longint unsigned x, x2, term, rad;
    longint s;
    for (int k = 0; k <= 1024; k++) begin
      x = (64'(k) * HALF_PI_Q30) >> 10;
      x2 = (x * x) >> 30;
      term = x;
      s = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        s = (n % 2 == 1) ? s - longint'(term) : s + longint'(term);
      end
      if (s < 0) s = 0;
      s = (s + 16384) >>> 15;
      sine_q15[k] = (s > 32767) ? 32767 : s;
    end
    atan_turns[0] = 64'h2000_0000;
    for (int i = 1; i < 31; i++) begin
      rad = 0;
      for (int j = 0; i * (2 * j + 1) <= 32; j++) begin
        term = (64'd1 << (32 - i * (2 * j + 1))) / 64'(2 * j + 1);
        rad = (j % 2 == 1) ? rad - term : rad + term;
      end
      atan_turns[i] = (rad * TURNS_PER_RAD_Q32 + 64'h8000_0000) >> 32;
    end
  endtask

  function automatic longint clamp_sum(longint v);
    return (v > SUM_TOP) ? SUM_TOP : ((v < SUM_BOTTOM) ? SUM_BOTTOM : v);
  endfunction

  // Per-frame mean, rounded half away from zero and clamped to 26 bits.
  function automatic longint frame_mean(longint acc, longint divisor);
    longint q;
    q = ((acc < 0 ? -acc : acc) + divisor / 2) / divisor;
    if (acc < 0) return (q > -MEAN_BOTTOM) ? MEAN_BOTTOM : -q;
    return (q > MEAN_TOP) ? MEAN_TOP : q;
  endfunction

  function automatic longint unsigned nearest_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (v > r) r++;
    return r;
  endfunction

  // Vectoring CORDIC; the left half plane is folded over by half a turn.
  function automatic logic [31:0] vector_angle(longint ix, longint qy);
    longint x, y, dx, dy;
    logic [31:0] z;
    z = 32'h0;
    if (ix == 0 && qy == 0) return z;
    if (ix < 0) begin
      ix = -ix;
      qy = -qy;
      z = 32'h8000_0000;
    end
    x = ix <<< 30;
    y = qy <<< 30;
    for (int i = 0; i < 31; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_turns[i][31:0];
      end else begin
        x -= dx; y += dy; z -= atan_turns[i][31:0];
      end
    end
    return z;
  endfunction

  // Updates the predicted state for one accepted beat and queues the
  // result that a read produces.
  task automatic predict_beat(cmd_e cmd, logic [15:0] pix, logic [15:0] smp,
                              logic [31:0] stamp, logic fend);
    logic [31:0] ph, dt;
    logic [1:0]  quadrant;
    int          j;
    longint      lo, hi, sn, cs, mi, mq;
    logic [32:0] rounded;
    pixel_result_t res;
    case (cmd)
      CMD_ACC: begin
        if (frame_count < 65535) begin
          dt = stamp - ref_start_time;
          ph = ref_phase_rate * dt;
          quadrant = ph[31:30];
          j = int'(ph[29:20]);
          lo = sine_q15[j];
          hi = sine_q15[1024 - j];
          sn = (quadrant == 0) ? lo : (quadrant == 1) ? hi : (quadrant == 2) ? -lo : -hi;
          cs = (quadrant == 0) ? hi : (quadrant == 1) ? -lo : (quadrant == 2) ? -hi : lo;
          if (frame_count == 0) begin
            in_phase_acc[pix] = 2 * longint'(smp) * cs;
            quad_acc[pix] = 2 * longint'(smp) * sn;
          end else begin
            in_phase_acc[pix] = clamp_sum(in_phase_acc[pix] + 2 * longint'(smp) * cs);
            quad_acc[pix] = clamp_sum(quad_acc[pix] + 2 * longint'(smp) * sn);
          end
          if (!fresh_pixel.exists(pix)) begin
            fresh_pixel[pix] = 1'b1;
            fresh_list.push_back(pix);
          end
          if (fend) frame_count++;
        end
      end
      CMD_READ: begin
        res = '0;
        if (frame_count != 0) begin
          mi = frame_mean(in_phase_acc[pix], longint'(frame_count) * 128);
          mq = frame_mean(quad_acc[pix], longint'(frame_count) * 128);
          rounded = {1'b0, vector_angle(mi, mq)} + 33'h8000;
          res.valid_res = 1'b1;
          res.in_phase = mi[25:0];
          res.quadrature = mq[25:0];
          res.amplitude = 26'(nearest_root(64'(mi * mi) + 64'(mq * mq)));
          res.angle = rounded[31:16];
        end
        pending_results.push_back(res);
      end
      CMD_RESTART: begin
        frame_count = 0;
        fresh_pixel.delete();
        fresh_list.delete();
      end
      default: ;
    endcase
  endtask

  // Offers one beat, with a random idle gap first, and waits until it is
  // taken. Called at a rising edge; returns at the edge that accepted it.
  task automatic send_beat(cmd_e cmd, logic [15:0] pix, logic [15:0] smp,
                           logic [31:0] stamp, logic fend);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {stamp, smp, pix};
    s_axis_tlast <= fend;
    s_axis_tuser <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_beat(cmd, pix, smp, stamp, fend);
  endtask

  // Lets every expected result arrive, then gives a finished accumulate
  // time to retire so that the block is idle.
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // The write enable drops after each write, before the next write may start.
  task automatic write_register(cfg_reg_e idx, logic [31:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_START_TIME) ref_start_time = value;
    else ref_phase_rate = value;
    @(posedge clk_i);
  endtask

  // A read may only address a pixel sampled since the last restart once a
  // frame is complete; with no frame every pixel reads as empty.
  function automatic logic [15:0] pick_read_pixel();
    if (frame_count == 0 || fresh_list.size() == 0) return 16'($urandom);
    return 16'(fresh_list[$urandom_range(fresh_list.size() - 1)]);
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random_beat();
    int unsigned roll;
    logic [15:0] pix;
    roll = $urandom_range(99);
    if (roll < 72) begin
      // Mostly a small pool of pixels so that sums build up over frames.
      // After the first frame a sample only goes to a pixel holding a sum.
      pix = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(31));
      if (frame_count != 0 && !in_phase_acc.exists(pix))
        pix = pick_read_pixel();
      send_beat(CMD_ACC, pix, pick_sample(), $urandom, $urandom_range(7) == 0);
    end else if (roll < 96) begin
      send_beat(CMD_READ, pick_read_pixel(), 16'($urandom), $urandom, 1'($urandom));
    end else if (roll < 97) begin
      send_beat(CMD_RESTART, 16'($urandom), 16'($urandom), $urandom, 1'($urandom));
    end else begin
      send_beat(CMD_UNUSED, 16'($urandom), 16'($urandom), $urandom, 1'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stalls, or a long hold counted down here.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (recv_hold != 0) begin
      m_axis_tready <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else begin
      m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic compare_field(string name, logic [25:0] expected, logic [25:0] actual);
    if (expected !== actual) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expected, actual);
      error_count++;
    end
  endtask

  // Each result beat is checked against the oldest predicted read.
  always @(posedge clk_i) begin
    pixel_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h / %b", $time, m_axis_tdata,
                 m_axis_tuser);
        error_count++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        compare_field("valid_res", 26'(want.valid_res), 26'(m_axis_tuser));
        compare_field("in_phase", want.in_phase, m_axis_tdata[25:0]);
        compare_field("quadrature", want.quadrature, m_axis_tdata[51:26]);
        compare_field("amplitude", want.amplitude, m_axis_tdata[77:52]);
        compare_field("angle", 26'(want.angle), 26'(m_axis_tdata[93:78]));
      end
    end
  end

  // Hang detection: cycles in a row with no beat taken on either side.
  always @(posedge clk_i) begin
    int unsigned quiet;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= HANG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  // Field extremes, every command, and the named corner cases: reads before
  // any frame, overwrite in the first frame, zero vector, half-turn angle.
  task automatic test_directed();
    write_register(REG_START_TIME, 32'h0);
    write_register(REG_PHASE_RATE, 32'h0);
    send_beat(CMD_READ, 16'hFFFF, 16'h0, 32'h0, 1'b0);
    send_beat(CMD_ACC, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    send_beat(CMD_ACC, 16'hFFFF, 16'h0000, 32'h0, 1'b0);
    send_beat(CMD_ACC, 16'h0001, 16'h8000, 32'h1234_5678, 1'b0);
    send_beat(CMD_ACC, 16'h0000, 16'h0001, 32'h0, 1'b1);
    send_beat(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_beat(CMD_READ, 16'h0000, 16'h0, 32'h0, 1'b0);
    send_beat(CMD_READ, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_beat(CMD_READ, 16'h0001, 16'h0, 32'h0, 1'b0);
    drain_block();
    // Half a turn per microsecond: one step from the start puts cosine at -1.
    write_register(REG_START_TIME, 32'hFFFF_FFFF);
    write_register(REG_PHASE_RATE, 32'h8000_0000);
    send_beat(CMD_RESTART, 16'h0, 16'h0, 32'h0, 1'b0);
    send_beat(CMD_ACC, 16'h0002, 16'hFFFF, 32'h0000_0000, 1'b0);
    send_beat(CMD_ACC, 16'h0003, 16'h4000, 32'h0000_0001, 1'b1);
    send_beat(CMD_ACC, 16'h0002, 16'h00FF, 32'h8000_0000, 1'b0);
    send_beat(CMD_READ, 16'h0002, 16'h0, 32'h0, 1'b0);
    send_beat(CMD_READ, 16'h0003, 16'h0, 32'h0, 1'b0);
    send_beat(CMD_RESTART, 16'h0, 16'h0, 32'h0, 1'b0);
    send_beat(CMD_READ, 16'h0003, 16'h0, 32'h0, 1'b0);
    drain_block();
  endtask

  // Random traffic through the four handshake settings, with new register
  // values between phases.
  task automatic test_random_traffic();
    int unsigned send_pct[4] = '{0, 68, 0, 7};
    int unsigned recv_pct[4] = '{0, 0, 68, 7};
    logic [31:0] starts[4] = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0};
    logic [31:0] rates[4] = '{32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0};
    for (int p = 0; p < 4; p++) begin
      write_register(REG_START_TIME, (p >= 2) ? $urandom : starts[p]);
      write_register(REG_PHASE_RATE, (p >= 2) ? $urandom : rates[p]);
      send_idle_pct = send_pct[p];
      recv_stall_pct = recv_pct[p];
      repeat (480) send_random_beat();
      drain_block();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // The receiver stops for a long stretch while reads keep coming, so the
  // output register fills and the input side has to stall.
  task automatic test_output_backpressure();
    write_register(REG_PHASE_RATE, 32'h0123_4567);
    send_beat(CMD_RESTART, 16'h0, 16'h0, 32'h0, 1'b0);
    send_beat(CMD_ACC, 16'h0010, 16'hABCD, $urandom, 1'b1);
    recv_hold = HOLD_CYCLES;
    repeat (12) send_beat(CMD_READ, pick_read_pixel(), 16'h0, $urandom, 1'b0);
    drain_block();
  endtask

  // A run of frames on one pixel at full cosine, so the mean divides by a
  // large frame count, then a restart that returns to overwriting.
  task automatic test_frame_count();
    write_register(REG_PHASE_RATE, 32'h0);
    send_beat(CMD_RESTART, 16'h0, 16'h0, 32'h0, 1'b0);
    repeat (FRAME_RUN) send_beat(CMD_ACC, 16'h0007, 16'hFFFF, $urandom, 1'b1);
    send_beat(CMD_READ, 16'h0007, 16'h0, 32'h0, 1'b0);
    send_beat(CMD_ACC, 16'h0007, 16'h1234, $urandom, 1'b1);
    send_beat(CMD_READ, 16'h0007, 16'h0, 32'h0, 1'b0);
    send_beat(CMD_RESTART, 16'h0, 16'h0, 32'h0, 1'b0);
    send_beat(CMD_ACC, 16'h0007, 16'h0100, $urandom, 1'b1);
    send_beat(CMD_READ, 16'h0007, 16'h0, 32'h0, 1'b0);
    drain_block();
  endtask

  initial begin
    build_lookup_tables();
    ref_start_time = 0;
    ref_phase_rate = 0;
    frame_count = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_traffic();
    test_output_backpressure();
    test_frame_count();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
